>>> sv/rrjs_pkg.sv
// Shared types and constants for the round-robin job scheduler.
`timescale 1ns / 1ps

package rrjs_pkg;

    localparam logic REQ_ARRIVE = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    localparam logic [7:0] SLICE_RESET = 8'd1;
    localparam logic [7:0] SLICE_MAX   = 8'hFF;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  arrive_job_id;
        logic [15:0] arrive_service;
    } in_item_t;

    typedef struct packed {
        logic       busy_res;
        logic [7:0] run_job_id;
        logic       job_finished;
        logic       arrival_dropped;
        logic [4:0] queue_count;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] remaining;
    } job_t;

    typedef struct packed {
        logic arrive;
        logic idle_tick;
        logic rotate;
        logic run;
    } rrjs_cmd_t;

    typedef struct packed {
        logic rot_due;
        logic q_empty;
        logic out_free;
    } rrjs_stat_t;

endpackage

>>> sv/rrjs_ctrl.sv
// Sequencing state machine that steps each item through the datapath.
`timescale 1ns / 1ps

module rrjs_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               req_type,
    output logic               in_ready,
    input  rrjs_pkg::rrjs_stat_t stat,
    output rrjs_pkg::rrjs_cmd_t  cmd
);

    typedef enum logic [3:0]
    {
        S_IDLE   = 4'b0001,
        S_ROT    = 4'b0010,
        S_RUN_RD = 4'b0100,
        S_RUN_WR = 4'b1000
    } ctrl_state_t;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = stat.out_free;
                if (in_valid && stat.out_free)
                begin
                    if (req_type == rrjs_pkg::REQ_ARRIVE)
                    begin
                        cmd.arrive = 1'b1;
                    end
                    else if (stat.q_empty)
                    begin
                        cmd.idle_tick = 1'b1;
                    end
                    else if (stat.rot_due)
                    begin
                        state_next = S_ROT;
                    end
                    else
                    begin
                        state_next = S_RUN_WR;
                    end
                end
            end
            S_ROT:
            begin
                cmd.rotate = 1'b1;
                state_next = S_RUN_RD;
            end
            S_RUN_RD:
            begin
                state_next = S_RUN_WR;
            end
            S_RUN_WR:
            begin
                cmd.run    = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> sv/rrjs_dp.sv
// Job queue memory, pointers, slice counter and result register.
`timescale 1ns / 1ps

module rrjs_dp
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [7:0]           cfg_wdata,
    input  rrjs_pkg::in_item_t   in_item,
    input  rrjs_pkg::rrjs_cmd_t  cmd,
    output rrjs_pkg::rrjs_stat_t stat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rrjs_pkg::out_item_t  out_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int EXT_W = (CNT_W > 5) ? CNT_W : 5;

    rrjs_pkg::job_t mem [QUEUE_DEPTH];
    rrjs_pkg::job_t rd_data_reg;

    logic [7:0]       time_slice_reg, time_slice_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             running_reg, running_next;
    logic [7:0]       slice_used_reg, slice_used_next;
    logic             out_valid_reg, out_valid_next;
    rrjs_pkg::out_item_t out_item_reg, out_item_next;

    logic             mem_we;
    logic [PTR_W-1:0] mem_waddr;
    rrjs_pkg::job_t   mem_wdata;

    logic [7:0]       slice_eff;
    logic             q_full;
    logic [PTR_W-1:0] head_inc, tail_inc;
    logic [15:0]      rem_new;
    logic [7:0]       used_base;
    logic [CNT_W-1:0] count_res;
    logic [EXT_W-1:0] count_ext;
    logic             load_out;

    assign slice_eff = (time_slice_reg == 8'd0) ? rrjs_pkg::SLICE_RESET : time_slice_reg;
    assign q_full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_inc  = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(head_reg + 1'b1);
    assign tail_inc  = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(tail_reg + 1'b1);
    assign rem_new   = (rd_data_reg.remaining == 16'd0) ? 16'd0 :
                       16'(rd_data_reg.remaining - 16'd1);
    assign used_base = running_reg ? slice_used_reg : 8'd0;

    assign stat.q_empty  = (count_reg == '0);
    assign stat.rot_due  = running_reg && (count_reg != '0) && (slice_used_reg >= slice_eff);
    assign stat.out_free = !out_valid_reg || out_ready;

    assign load_out  = cmd.arrive || cmd.idle_tick || cmd.run;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        time_slice_next = cfg_we ? cfg_wdata : time_slice_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        running_next    = running_reg;
        slice_used_next = slice_used_reg;
        mem_we          = 1'b0;
        mem_waddr       = tail_reg;
        mem_wdata       = rd_data_reg;
        out_item_next   = '0;

        if (cmd.arrive)
        begin
            if (q_full || (in_item.arrive_service == 16'd0))
            begin
                out_item_next.arrival_dropped = 1'b1;
            end
            else
            begin
                mem_we              = 1'b1;
                mem_wdata.id        = in_item.arrive_job_id;
                mem_wdata.remaining = in_item.arrive_service;
                tail_next           = tail_inc;
                count_next          = CNT_W'(count_reg + 1'b1);
            end
        end

        if (cmd.idle_tick)
        begin
            running_next = 1'b0;
        end

        if (cmd.rotate)
        begin
            mem_we          = 1'b1;
            tail_next       = tail_inc;
            head_next       = head_inc;
            running_next    = 1'b0;
            slice_used_next = 8'd0;
        end

        if (cmd.run)
        begin
            mem_we                   = 1'b1;
            mem_waddr                = head_reg;
            mem_wdata.remaining      = rem_new;
            out_item_next.busy_res   = 1'b1;
            out_item_next.run_job_id = rd_data_reg.id;
            if (rem_new == 16'd0)
            begin
                out_item_next.job_finished = 1'b1;
                head_next                  = head_inc;
                count_next                 = CNT_W'(count_reg - 1'b1);
                running_next               = 1'b0;
                slice_used_next            = 8'd0;
            end
            else
            begin
                running_next    = 1'b1;
                slice_used_next = (used_base == rrjs_pkg::SLICE_MAX) ? rrjs_pkg::SLICE_MAX :
                                  8'(used_base + 8'd1);
            end
        end

        count_res                 = count_next;
        count_ext                 = EXT_W'(count_res);
        out_item_next.queue_count = count_ext[4:0];

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_slice_reg <= rrjs_pkg::SLICE_RESET;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            running_reg    <= 1'b0;
            slice_used_reg <= 8'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            time_slice_reg <= time_slice_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            running_reg    <= running_next;
            slice_used_reg <= slice_used_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_item_reg <= out_item_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[head_reg];
    end

endmodule

>>> sv/round_robin_job_scheduler.sv
// Top level of the round-robin job scheduler with a time slice.
// An arrival or an idle tick gives its result in the cycle after acceptance.
// A run tick uses S_RUN_WR; a rotating tick uses S_ROT, S_RUN_RD and S_RUN_WR.
// A tick that runs a job reads the queue memory through its single registered read port.
// The next item is accepted once the result register is free and the block is idle.
// Reset clears pointers, job count, running state and sets the time slice to 1.
`timescale 1ns / 1ps

module round_robin_job_scheduler
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  rrjs_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output rrjs_pkg::out_item_t out_item
);

    rrjs_pkg::rrjs_cmd_t  cmd;
    rrjs_pkg::rrjs_stat_t stat;

    rrjs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (in_item.req_type),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rrjs_dp
    #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_item   (in_item),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

>>> sv/rrjs_checker.sv
// Port-level checks for the round-robin job scheduler, bound to the top level.
`timescale 1ns / 1ps

module rrjs_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input rrjs_pkg::in_item_t  in_item,
    input logic                out_valid,
    input logic                out_ready,
    input rrjs_pkg::out_item_t out_item
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("Result item changed while stalled.");

    a_zero_service_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_item.req_type == rrjs_pkg::REQ_ARRIVE)
        && (in_item.arrive_service == 16'd0)
        |=> out_valid && out_item.arrival_dropped && !out_item.busy_res)
        else $error("Arrival with zero service was not dropped.");

    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.busy_res |-> (out_item.run_job_id == 8'd0)
        && !out_item.job_finished)
        else $error("Idle result carries a job id or a finish flag.");

    a_busy_not_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.busy_res |-> !out_item.arrival_dropped)
        else $error("Tick result flags a dropped arrival.");

endmodule

bind round_robin_job_scheduler rrjs_checker u_rrjs_checker (.*);
